FILE: hdl/paf_pkg.sv
package paf_pkg;

  // default sizes
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int MAX_LABELS_DEF = 255;
  localparam int VECTOR_LEN_DEF = 4;
  localparam int FRAC_BITS_DEF  = 8;

  // fixed field widths
  localparam int NIN      = 4;
  localparam int OP_W     = 2;
  localparam int INDEX_W  = 16;
  localparam int LABEL_W  = 8;
  localparam int SIM_W    = 16;
  localparam int COORD_W  = 9;
  localparam int THR_W    = 16;
  localparam int COUNT_W  = 17;
  localparam int SUM_W    = 32;
  localparam int GROWN_W  = 16;
  localparam int DIST_W   = 2 * SIM_W + 2;
  localparam int DIV_CW   = $clog2(SUM_W);
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_AW   = 4;
  localparam int CFG_DW   = 32;

  // operation codes
  localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
  localparam logic [OP_W-1:0] OP_RUN  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ = 2'd2;

  // result kinds
  localparam logic KIND_RUN  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_THR    = 2'd2;

  // neighbour directions
  localparam logic [1:0] DIR_LEFT  = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_UP    = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

  typedef struct packed {
    logic run_init;
    logic scan_rd;
    logic scan_seed;
    logic scan_acc;
    logic scan_adv;
    logic mn_rd;
    logic div_start;
    logic mn_store;
    logic mn_wr;
    logic mn_adv;
    logic gr_pop;
    logic gr_ent;
    logic gr_nbrd;
    logic dir_adv;
    logic dst_init;
    logic dst_step;
    logic gr_win;
    logic rd_out;
    logic run_out;
  } cmd_t;

  typedef struct packed {
    logic lab_nz;
    logic scan_last;
    logic mn_last;
    logic div_done;
    logic sum_valid;
    logic comp_last;
    logic q_empty;
    logic nb_in;
    logic dir_last;
    logic cand;
    logic win;
    logic out_free;
  } sts_t;

endpackage

FILE: hdl/paf_ram.sv
module paf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/paf_div.sv
module paf_div (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic signed [paf_pkg::SUM_W-1:0]      dividend,
  input  logic [paf_pkg::COUNT_W-1:0]           divisor,
  output logic                                  done,
  output logic signed [paf_pkg::SIM_W-1:0]      quot
);
  import paf_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIV_CW-1:0] cnt_r, cnt_nxt;
  logic              neg_r, neg_nxt;
  logic [COUNT_W-1:0] dvs_r, dvs_nxt;
  logic [COUNT_W-1:0] rem_r, rem_nxt;
  logic [SUM_W-1:0]  q_r, q_nxt;
  logic [COUNT_W:0]  trial;
  logic [SUM_W-1:0]  q_signed;

  // restoring division, one quotient bit a cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    trial    = {rem_r, q_r[SUM_W-1]} - {1'b0, dvs_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      neg_nxt  = dividend[SUM_W-1];
      dvs_nxt  = divisor;
      rem_nxt  = '0;
      q_nxt    = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
    end else if (busy_r) begin
      if (!trial[COUNT_W]) begin
        rem_nxt = trial[COUNT_W-1:0];
      end else begin
        rem_nxt = {rem_r[COUNT_W-2:0], q_r[SUM_W-1]};
      end
      q_nxt = {q_r[SUM_W-2:0], ~trial[COUNT_W]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CW'(SUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    neg_r <= neg_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign q_signed = neg_r ? (~q_r + 1'b1) : q_r;
  assign quot     = q_signed[SIM_W-1:0];
  assign done     = done_r;

endmodule

FILE: hdl/paf_dp.sv
module paf_dp #(
  parameter int MAX_WIDTH  = paf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = paf_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_LABELS = paf_pkg::MAX_LABELS_DEF,
  parameter int VECTOR_LEN = paf_pkg::VECTOR_LEN_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_acc,
  input  logic [paf_pkg::OP_W-1:0]            in_op,
  input  logic [paf_pkg::INDEX_W-1:0]         in_idx,
  input  logic                                in_text,
  input  logic [paf_pkg::LABEL_W-1:0]         in_label,
  input  logic [paf_pkg::NIN*paf_pkg::SIM_W-1:0] in_sims,
  input  logic [paf_pkg::COORD_W-1:0]         frame_w,
  input  logic [paf_pkg::COORD_W-1:0]         frame_h,
  input  logic [paf_pkg::THR_W-1:0]           thr,
  input  paf_pkg::cmd_t                       cmd,
  output paf_pkg::sts_t                       sts,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic                                out_kind,
  output logic [paf_pkg::LABEL_W-1:0]         out_label,
  output logic [paf_pkg::GROWN_W-1:0]         out_count
);
  import paf_pkg::*;

  localparam int NPIX  = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = NPIX > 1 ? $clog2(NPIX) : 1;
  localparam int NCOMP = VECTOR_LEN < NIN ? VECTOR_LEN : NIN;
  localparam int KW    = NCOMP > 1 ? $clog2(NCOMP) : 1;
  localparam int NLAB  = MAX_LABELS + 1;
  localparam int LAW   = $clog2(NLAB);
  localparam int TVW   = 1 + NCOMP * SIM_W;
  localparam int SRW   = NCOMP * SUM_W + COUNT_W;
  localparam int MRW   = NCOMP * SIM_W;
  localparam int QW    = LABEL_W + 2 * COORD_W + AW;

  // pixel stores
  logic               lab_we, lab_re, tv_we, tv_re;
  logic [AW-1:0]      lab_waddr, pix_raddr;
  logic [LABEL_W-1:0] lab_wdata, lab_rdata;
  logic [TVW-1:0]     tv_wdata, tv_rdata;

  // kernel sums and means
  logic               sum_we, sum_re, mean_we, mean_re;
  logic [LAW-1:0]     sum_raddr, mean_raddr;
  logic [SRW-1:0]     sum_wdata, sum_rdata, sum_old;
  logic [MRW-1:0]     mean_rdata;

  // grow queue
  logic               q_we, q_re;
  logic [QW-1:0]      q_wdata, q_rdata;
  logic [AW:0]        q_head_r, q_head_nxt, q_tail_r, q_tail_nxt;

  // scan position
  logic [COORD_W-1:0] sx_r, sx_nxt, sy_r, sy_nxt;
  logic [AW-1:0]      sidx_r, sidx_nxt;

  logic [LAW-1:0]     lbl_r, lbl_nxt;
  logic [LAW-1:0]     sum_addr_r, sum_addr_nxt;
  logic [NLAB-1:0]    sum_vld_r, sum_vld_nxt;
  logic [KW-1:0]      k_r, k_nxt;
  logic [MRW-1:0]     mrow_r, mrow_nxt;
  logic [1:0]         dir_r, dir_nxt;
  logic [DIST_W-1:0]  dist_r, dist_nxt;
  logic [2*THR_W-1:0] thr2_r, thr2_nxt;
  logic [GROWN_W-1:0] grown_r, grown_nxt;
  logic               rd_oob_r, rd_oob_nxt;

  logic               ov_r, ov_nxt, okind_r, okind_nxt;
  logic [LABEL_W-1:0] olab_r, olab_nxt;
  logic [GROWN_W-1:0] ocnt_r, ocnt_nxt;

  // divider
  logic               div_done;
  logic signed [SIM_W-1:0] div_q;
  logic [SUM_W-1:0]   div_num;

  // queue entry fields
  logic [LABEL_W-1:0] e_lab;
  logic [COORD_W-1:0] e_x, e_y;
  logic [AW-1:0]      e_idx;

  // neighbour
  logic               nb_in;
  logic [COORD_W-1:0] nx, ny;
  logic [AW-1:0]      nidx;

  logic               ld_wr, rd_iss, in_store, q_room;
  logic signed [SIM_W:0] dcomp;
  logic [SIM_W-1:0]   dabs;
  logic [2*SIM_W-1:0] dsq;
  logic [SIM_W-1:0]   mk, vk;

  assign in_store = (int'(in_idx) < NPIX);
  assign ld_wr    = in_acc && (in_op == OP_LOAD) && in_store;
  assign rd_iss   = in_acc && (in_op == OP_READ);
  assign q_room   = (int'(q_tail_r) < NPIX);

  assign {e_lab, e_y, e_x, e_idx} = q_rdata;

  always_comb begin
    nb_in = 1'b0;
    nx    = e_x;
    ny    = e_y;
    nidx  = e_idx;
    case (dir_r)
      DIR_LEFT: begin
        nb_in = (e_x != '0);
        nx    = e_x - 1'b1;
        nidx  = e_idx - 1'b1;
      end
      DIR_RIGHT: begin
        nb_in = ({1'b0, e_x} + 1'b1) < {1'b0, frame_w};
        nx    = e_x + 1'b1;
        nidx  = e_idx + 1'b1;
      end
      DIR_UP: begin
        nb_in = (e_y != '0);
        ny    = e_y - 1'b1;
        nidx  = e_idx - AW'(frame_w);
      end
      DIR_DOWN: begin
        nb_in = ({1'b0, e_y} + 1'b1) < {1'b0, frame_h};
        ny    = e_y + 1'b1;
        nidx  = e_idx + AW'(frame_w);
      end
      default: begin
        nb_in = 1'b0;
      end
    endcase
  end

  // pixel store ports
  always_comb begin
    lab_we    = 1'b0;
    lab_waddr = AW'(in_idx);
    lab_wdata = (int'(in_label) > MAX_LABELS) ? '0 : in_label;
    if (cmd.gr_win) begin
      lab_we    = 1'b1;
      lab_waddr = nidx;
      lab_wdata = e_lab;
    end else if (ld_wr) begin
      lab_we = 1'b1;
    end
    tv_we = ld_wr;
    tv_wdata[0] = in_text;
    for (int k = 0; k < NCOMP; k++) begin
      tv_wdata[1 + k*SIM_W +: SIM_W] = in_sims[k*SIM_W +: SIM_W];
    end
    if (rd_iss) begin
      pix_raddr = AW'(in_idx);
    end else if (cmd.scan_rd) begin
      pix_raddr = sidx_r;
    end else begin
      pix_raddr = nidx;
    end
    lab_re = rd_iss || cmd.scan_rd || cmd.gr_nbrd;
    tv_re  = cmd.scan_rd || cmd.gr_nbrd;
  end

  paf_ram #(.WIDTH(LABEL_W), .DEPTH(NPIX)) u_lab_ram (
    .clk(clk), .we(lab_we), .waddr(lab_waddr), .wdata(lab_wdata),
    .re(lab_re), .raddr(pix_raddr), .rdata(lab_rdata)
  );

  paf_ram #(.WIDTH(TVW), .DEPTH(NPIX)) u_tv_ram (
    .clk(clk), .we(tv_we), .waddr(AW'(in_idx)), .wdata(tv_wdata),
    .re(tv_re), .raddr(pix_raddr), .rdata(tv_rdata)
  );

  // kernel sums, rows cleared through valid bits at run start
  assign sum_old = sum_vld_r[sum_addr_r] ? sum_rdata : '0;
  always_comb begin
    for (int k = 0; k < NCOMP; k++) begin
      sum_wdata[k*SUM_W +: SUM_W] = sum_old[k*SUM_W +: SUM_W]
        + {{(SUM_W-SIM_W){tv_rdata[k*SIM_W + SIM_W]}}, tv_rdata[1 + k*SIM_W +: SIM_W]};
    end
    sum_wdata[NCOMP*SUM_W +: COUNT_W] = sum_old[NCOMP*SUM_W +: COUNT_W] + 1'b1;
  end
  assign sum_we    = cmd.scan_acc;
  assign sum_re    = cmd.scan_seed || cmd.mn_rd;
  assign sum_raddr = cmd.scan_seed ? lab_rdata[LAW-1:0] : lbl_r;

  paf_ram #(.WIDTH(SRW), .DEPTH(NLAB)) u_sum_ram (
    .clk(clk), .we(sum_we), .waddr(sum_addr_r), .wdata(sum_wdata),
    .re(sum_re), .raddr(sum_raddr), .rdata(sum_rdata)
  );

  assign div_num = sum_rdata[k_r*SUM_W +: SUM_W];

  paf_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .dividend(div_num), .divisor(sum_rdata[NCOMP*SUM_W +: COUNT_W]),
    .done(div_done), .quot(div_q)
  );

  assign mean_we    = cmd.mn_wr;
  assign mean_re    = cmd.gr_ent;
  assign mean_raddr = e_lab[LAW-1:0];

  paf_ram #(.WIDTH(MRW), .DEPTH(NLAB)) u_mean_ram (
    .clk(clk), .we(mean_we), .waddr(lbl_r), .wdata(mrow_r),
    .re(mean_re), .raddr(mean_raddr), .rdata(mean_rdata)
  );

  // grow queue
  always_comb begin
    q_we    = 1'b0;
    q_wdata = {lab_rdata, sy_r, sx_r, sidx_r};
    if (cmd.scan_seed) begin
      q_we = q_room;
    end else if (cmd.gr_win) begin
      q_we    = q_room;
      q_wdata = {e_lab, ny, nx, nidx};
    end
  end
  assign q_re = cmd.gr_pop;

  paf_ram #(.WIDTH(QW), .DEPTH(NPIX)) u_q_ram (
    .clk(clk), .we(q_we), .waddr(q_tail_r[AW-1:0]), .wdata(q_wdata),
    .re(q_re), .raddr(q_head_r[AW-1:0]), .rdata(q_rdata)
  );

  // squared distance, one component a cycle
  assign mk    = mean_rdata[k_r*SIM_W +: SIM_W];
  assign vk    = tv_rdata[1 + k_r*SIM_W +: SIM_W];
  assign dcomp = $signed({mk[SIM_W-1], mk}) - $signed({vk[SIM_W-1], vk});
  assign dabs  = dcomp[SIM_W] ? SIM_W'(-dcomp) : dcomp[SIM_W-1:0];
  assign dsq   = dabs * dabs;

  always_comb begin
    q_head_nxt   = q_head_r;
    q_tail_nxt   = q_tail_r;
    sx_nxt       = sx_r;
    sy_nxt       = sy_r;
    sidx_nxt     = sidx_r;
    lbl_nxt      = lbl_r;
    sum_addr_nxt = sum_addr_r;
    sum_vld_nxt  = sum_vld_r;
    k_nxt        = k_r;
    mrow_nxt     = mrow_r;
    dir_nxt      = dir_r;
    dist_nxt     = dist_r;
    thr2_nxt     = thr2_r;
    grown_nxt    = grown_r;
    rd_oob_nxt   = rd_oob_r;
    ov_nxt       = ov_r && !out_ready;
    okind_nxt    = okind_r;
    olab_nxt     = olab_r;
    ocnt_nxt     = ocnt_r;

    if (rd_iss) begin
      rd_oob_nxt = !in_store;
    end
    if (cmd.run_init) begin
      q_head_nxt  = '0;
      q_tail_nxt  = '0;
      sx_nxt      = '0;
      sy_nxt      = '0;
      sidx_nxt    = '0;
      lbl_nxt     = LAW'(1);
      sum_vld_nxt = '0;
      thr2_nxt    = thr * thr;
      grown_nxt   = '0;
    end
    if (cmd.scan_seed) begin
      sum_addr_nxt = lab_rdata[LAW-1:0];
    end
    if ((cmd.scan_seed || cmd.gr_win) && q_room) begin
      q_tail_nxt = q_tail_r + 1'b1;
    end
    if (cmd.scan_acc) begin
      sum_vld_nxt[sum_addr_r] = 1'b1;
    end
    if (cmd.scan_adv) begin
      sidx_nxt = sidx_r + 1'b1;
      if (sx_r == frame_w - 1'b1) begin
        sx_nxt = '0;
        sy_nxt = sy_r + 1'b1;
      end else begin
        sx_nxt = sx_r + 1'b1;
      end
    end
    if (cmd.mn_rd) begin
      sum_addr_nxt = lbl_r;
      k_nxt        = '0;
    end
    if (cmd.mn_store) begin
      mrow_nxt[k_r*SIM_W +: SIM_W] = div_q;
      k_nxt = k_r + 1'b1;
    end
    if (cmd.mn_adv) begin
      lbl_nxt = lbl_r + 1'b1;
    end
    if (cmd.gr_pop) begin
      q_head_nxt = q_head_r + 1'b1;
    end
    if (cmd.gr_ent) begin
      dir_nxt = DIR_LEFT;
    end
    if (cmd.dir_adv) begin
      dir_nxt = dir_r + 1'b1;
    end
    if (cmd.dst_init) begin
      k_nxt    = '0;
      dist_nxt = '0;
    end
    if (cmd.dst_step) begin
      dist_nxt = dist_r + DIST_W'(dsq);
      k_nxt    = k_r + 1'b1;
    end
    if (cmd.gr_win && (grown_r != '1)) begin
      grown_nxt = grown_r + 1'b1;
    end
    if (cmd.rd_out) begin
      ov_nxt    = 1'b1;
      okind_nxt = KIND_READ;
      olab_nxt  = rd_oob_r ? '0 : lab_rdata;
      ocnt_nxt  = '0;
    end
    if (cmd.run_out) begin
      ov_nxt    = 1'b1;
      okind_nxt = KIND_RUN;
      olab_nxt  = '0;
      ocnt_nxt  = grown_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_head_r  <= '0;
      q_tail_r  <= '0;
      sum_vld_r <= '0;
      ov_r      <= 1'b0;
      grown_r   <= '0;
      dir_r     <= DIR_LEFT;
      k_r       <= '0;
      lbl_r     <= '0;
      sx_r      <= '0;
      sy_r      <= '0;
      sidx_r    <= '0;
    end else begin
      q_head_r  <= q_head_nxt;
      q_tail_r  <= q_tail_nxt;
      sum_vld_r <= sum_vld_nxt;
      ov_r      <= ov_nxt;
      grown_r   <= grown_nxt;
      dir_r     <= dir_nxt;
      k_r       <= k_nxt;
      lbl_r     <= lbl_nxt;
      sx_r      <= sx_nxt;
      sy_r      <= sy_nxt;
      sidx_r    <= sidx_nxt;
    end
    sum_addr_r <= sum_addr_nxt;
    mrow_r     <= mrow_nxt;
    dist_r     <= dist_nxt;
    thr2_r     <= thr2_nxt;
    rd_oob_r   <= rd_oob_nxt;
    okind_r    <= okind_nxt;
    olab_r     <= olab_nxt;
    ocnt_r     <= ocnt_nxt;
  end

  always_comb begin
    sts.lab_nz    = (lab_rdata != '0);
    sts.scan_last = (sx_r == frame_w - 1'b1) && (sy_r == frame_h - 1'b1);
    sts.mn_last   = (int'(lbl_r) == MAX_LABELS);
    sts.div_done  = div_done;
    sts.sum_valid = sum_vld_r[sum_addr_r];
    sts.comp_last = (int'(k_r) == NCOMP - 1);
    sts.q_empty   = (q_head_r == q_tail_r);
    sts.nb_in     = nb_in;
    sts.dir_last  = (dir_r == DIR_DOWN);
    sts.cand      = tv_rdata[0] && (lab_rdata == '0);
    sts.win       = (dist_r < DIST_W'(thr2_r));
    sts.out_free  = !ov_r || out_ready;
  end

  assign out_valid = ov_r;
  assign out_kind  = okind_r;
  assign out_label = olab_r;
  assign out_count = ocnt_r;

endmodule

FILE: hdl/paf_ctrl.sv
module paf_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic [paf_pkg::OP_W-1:0] in_op,
  output logic                     in_ready,
  input  paf_pkg::sts_t            sts,
  output paf_pkg::cmd_t            cmd
);
  import paf_pkg::*;

  typedef enum logic [16:0] {
    S_IDLE     = 17'b00000000000000001,
    S_RD       = 17'b00000000000000010,
    S_SCAN_RD  = 17'b00000000000000100,
    S_SCAN_LAB = 17'b00000000000001000,
    S_SCAN_ACC = 17'b00000000000010000,
    S_MN_RD    = 17'b00000000000100000,
    S_MN_CHK   = 17'b00000000001000000,
    S_MN_DIV   = 17'b00000000010000000,
    S_MN_NXT   = 17'b00000000100000000,
    S_MN_WR    = 17'b00000001000000000,
    S_GR_POP   = 17'b00000010000000000,
    S_GR_ENT   = 17'b00000100000000000,
    S_GR_NB    = 17'b00001000000000000,
    S_GR_CHK   = 17'b00010000000000000,
    S_GR_DST   = 17'b00100000000000000,
    S_GR_CMP   = 17'b01000000000000000,
    S_DONE     = 17'b10000000000000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_op)
            OP_RUN: begin
              cmd.run_init = 1'b1;
              state_nxt    = S_SCAN_RD;
            end
            OP_READ: begin
              state_nxt = S_RD;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_RD: begin
        if (sts.out_free) begin
          cmd.rd_out = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        state_nxt   = S_SCAN_LAB;
      end
      S_SCAN_LAB: begin
        if (sts.lab_nz) begin
          cmd.scan_seed = 1'b1;
          state_nxt     = S_SCAN_ACC;
        end else begin
          cmd.scan_adv = 1'b1;
          state_nxt    = sts.scan_last ? S_MN_RD : S_SCAN_RD;
        end
      end
      S_SCAN_ACC: begin
        cmd.scan_acc = 1'b1;
        cmd.scan_adv = 1'b1;
        state_nxt    = sts.scan_last ? S_MN_RD : S_SCAN_RD;
      end
      S_MN_RD: begin
        cmd.mn_rd = 1'b1;
        state_nxt = S_MN_CHK;
      end
      S_MN_CHK: begin
        if (sts.sum_valid) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_MN_DIV;
        end else begin
          cmd.mn_adv = 1'b1;
          state_nxt  = sts.mn_last ? S_GR_POP : S_MN_RD;
        end
      end
      S_MN_DIV: begin
        if (sts.div_done) begin
          cmd.mn_store = 1'b1;
          state_nxt    = sts.comp_last ? S_MN_WR : S_MN_NXT;
        end
      end
      S_MN_NXT: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_MN_DIV;
      end
      S_MN_WR: begin
        cmd.mn_wr  = 1'b1;
        cmd.mn_adv = 1'b1;
        state_nxt  = sts.mn_last ? S_GR_POP : S_MN_RD;
      end
      S_GR_POP: begin
        if (sts.q_empty) begin
          state_nxt = S_DONE;
        end else begin
          cmd.gr_pop = 1'b1;
          state_nxt  = S_GR_ENT;
        end
      end
      S_GR_ENT: begin
        cmd.gr_ent = 1'b1;
        state_nxt  = S_GR_NB;
      end
      S_GR_NB: begin
        if (sts.nb_in) begin
          cmd.gr_nbrd = 1'b1;
          state_nxt   = S_GR_CHK;
        end else if (sts.dir_last) begin
          state_nxt = S_GR_POP;
        end else begin
          cmd.dir_adv = 1'b1;
        end
      end
      S_GR_CHK: begin
        if (sts.cand) begin
          cmd.dst_init = 1'b1;
          state_nxt    = S_GR_DST;
        end else if (sts.dir_last) begin
          state_nxt = S_GR_POP;
        end else begin
          cmd.dir_adv = 1'b1;
          state_nxt   = S_GR_NB;
        end
      end
      S_GR_DST: begin
        cmd.dst_step = 1'b1;
        if (sts.comp_last) begin
          state_nxt = S_GR_CMP;
        end
      end
      S_GR_CMP: begin
        cmd.gr_win = sts.win;
        if (sts.dir_last) begin
          state_nxt = S_GR_POP;
        end else begin
          cmd.dir_adv = 1'b1;
          state_nxt   = S_GR_NB;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.run_out = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hdl/pixel_aggregation_flood_fill_top.sv
// pixel aggregation by flood fill
// input stream: in_tuser carries the op (load, run, read); in_tdata the pixel
// index, text flag, kernel label and four q8.8 similarity components.
// a load writes one pixel in the accept cycle, one beat per clock while idle,
// no result. a read puts the pixel label in the output register once that
// register is free. a run scans the frame, adding each labelled pixel into
// its kernel sums, works out each kernel mean with a shared serial divider,
// one component at a time for every label in use, then grows from a fifo,
// labelling each unlabelled in-frame text neighbour of a queued pixel that
// lies closer to its kernel mean than the threshold, and queueing it.
// one result beat gives the grown count.
// input is taken only while no run or read is in progress; loads need not
// wait for a pending result. one output register holds the result until
// out_tready; a stalled receiver holds a finishing read or run in place.
// reset returns the frame size and threshold registers to their defaults
// and empties the output; pixel stores hold nothing valid until loaded.
// registers over apb: 0x0 frame width, 0x4 frame height, 0x8 threshold.
module pixel_aggregation_flood_fill_top #(
  parameter int MAX_WIDTH  = paf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = paf_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_LABELS = paf_pkg::MAX_LABELS_DEF,
  parameter int VECTOR_LEN = paf_pkg::VECTOR_LEN_DEF,
  parameter int FRAC_BITS  = paf_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // pixel_index, text_flag, kernel_label, sim_a, sim_b, sim_c, sim_d, zero pad
  input  logic [paf_pkg::IN_DATA_W-1:0]     in_tdata,
  // op
  input  logic [paf_pkg::OP_W-1:0]          in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // pixel_label, grown_count
  output logic [paf_pkg::OUT_DATA_W-1:0]    out_tdata,
  // result_kind
  output logic                              out_tuser,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [paf_pkg::CFG_AW-1:0]        cfg_paddr,
  input  logic [paf_pkg::CFG_DW-1:0]        cfg_pwdata,
  output logic [paf_pkg::CFG_DW-1:0]        cfg_prdata,
  output logic                              cfg_pready
);
  import paf_pkg::*;

  localparam int THR_RST = (((8 << FRAC_BITS) + 5) / 10) % 65536;

  logic [COORD_W-1:0] fw_r, fw_nxt, fh_r, fh_nxt;
  logic [THR_W-1:0]   thr_r, thr_nxt;
  logic [COORD_W-1:0] w_eff, h_eff;
  logic               cfg_wr, in_acc;
  logic [1:0]         reg_sel;
  cmd_t               cmd;
  sts_t               sts;
  logic [LABEL_W-1:0] o_label;
  logic [GROWN_W-1:0] o_count;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_sel    = cfg_paddr[3:2];

  always_comb begin
    fw_nxt  = fw_r;
    fh_nxt  = fh_r;
    thr_nxt = thr_r;
    if (cfg_wr) begin
      case (reg_sel)
        REG_WIDTH:  fw_nxt  = cfg_pwdata[COORD_W-1:0];
        REG_HEIGHT: fh_nxt  = cfg_pwdata[COORD_W-1:0];
        REG_THR:    thr_nxt = cfg_pwdata[THR_W-1:0];
        default:    fw_nxt  = fw_r;
      endcase
    end
    case (reg_sel)
      REG_WIDTH:  cfg_prdata = CFG_DW'(fw_r);
      REG_HEIGHT: cfg_prdata = CFG_DW'(fh_r);
      REG_THR:    cfg_prdata = CFG_DW'(thr_r);
      default:    cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r  <= COORD_W'(256);
      fh_r  <= COORD_W'(256);
      thr_r <= THR_W'(THR_RST);
    end else begin
      fw_r  <= fw_nxt;
      fh_r  <= fh_nxt;
      thr_r <= thr_nxt;
    end
  end

  // frame size saturates to the built store size; a zero size reads as 1
  assign w_eff = (fw_r == '0) ? COORD_W'(1) :
                 (int'(fw_r) > MAX_WIDTH) ? COORD_W'(MAX_WIDTH) : fw_r;
  assign h_eff = (fh_r == '0) ? COORD_W'(1) :
                 (int'(fh_r) > MAX_HEIGHT) ? COORD_W'(MAX_HEIGHT) : fh_r;

  assign in_acc = in_tvalid && in_tready;

  paf_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_op(in_tuser), .in_ready(in_tready),
    .sts(sts), .cmd(cmd)
  );

  paf_dp #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_LABELS(MAX_LABELS), .VECTOR_LEN(VECTOR_LEN)
  ) u_dp (
    .clk(clk), .rst_n(rst_n),
    .in_acc(in_acc), .in_op(in_tuser),
    .in_idx(in_tdata[15:0]), .in_text(in_tdata[16]),
    .in_label(in_tdata[24:17]), .in_sims(in_tdata[88:25]),
    .frame_w(w_eff), .frame_h(h_eff), .thr(thr_r),
    .cmd(cmd), .sts(sts),
    .out_ready(out_tready), .out_valid(out_tvalid), .out_kind(out_tuser),
    .out_label(o_label), .out_count(o_count)
  );

  assign out_tdata = {o_count, o_label};

endmodule
